/* src/pmu_command_handshake_macros.svh */
// ----------------------------------------------------------------------------
// pmu_command_handshake_macros
// Assertion macros shared by the power-manager handshake block.
// ----------------------------------------------------------------------------
// Both macros expect clk and rst to be visible where they are used.
`ifndef PMU_COMMAND_HANDSHAKE_MACROS_SVH
`define PMU_COMMAND_HANDSHAKE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMU_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/pmu_pkg.sv */
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared constants and types of the power-manager command handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package pmu_pkg;

  localparam int BUF_BYTES_DEF  = 8;
  localparam int PRAM_BYTES_DEF = 128;

  // The first scratch bytes live in flip-flops, as the command decoder reads
  // and clears them directly.
  localparam int LO_BYTES = 4;
  localparam int LO_W     = $clog2(LO_BYTES);

  localparam logic [7:0] BYTE_IDLE = 8'hFF;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_XW_LEN      = 4'd1;
  localparam logic [3:0] ERR_XW_RANGE    = 4'd2;
  localparam logic [3:0] ERR_XW_INDEX    = 4'd3;
  localparam logic [3:0] ERR_NOP_LEN     = 4'd4;
  localparam logic [3:0] ERR_XR_REQ      = 4'd5;
  localparam logic [3:0] ERR_TIME_LEN    = 4'd6;
  localparam logic [3:0] ERR_OW_LEN      = 4'd7;
  localparam logic [3:0] ERR_OW_INDEX    = 4'd8;
  localparam logic [3:0] ERR_OR_LEN      = 4'd9;
  localparam logic [3:0] ERR_OR_INDEX    = 4'd10;
  localparam logic [3:0] ERR_UNKNOWN     = 4'd11;
  localparam logic [3:0] ERR_SEND_PEND   = 4'd12;

  // Access from the sequencer to the byte stores.
  typedef struct packed {
    logic       wr;
    logic       rd;
    logic       pram;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_req_t;

  // One result word.
  typedef struct packed {
    logic       ready_write;
    logic       ready_level;
    logic       bus_write;
    logic [7:0] bus_out;
    logic       task_request;
    logic [3:0] error_code;
  } rsp_t;

endpackage

`default_nettype wire

/* src/pmu_store.sv */
// ----------------------------------------------------------------------------
// pmu_store
// Parameter RAM and upper scratch buffer, with per-entry valid bits so that
// never-written entries read as zero straight after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pmu_store #(
  parameter int BUF_BYTES  = pmu_pkg::BUF_BYTES_DEF,
  parameter int PRAM_BYTES = pmu_pkg::PRAM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pmu_pkg::mem_req_t  req,
  output logic [7:0]         rd_data
);

  localparam int PA = $clog2(PRAM_BYTES);
  localparam int SA = $clog2(BUF_BYTES);

  logic [7:0]            pram_mem [PRAM_BYTES];
  logic [7:0]            scr_mem  [BUF_BYTES];
  logic [PRAM_BYTES-1:0] pram_vld;
  logic [BUF_BYTES-1:0]  scr_vld;

  logic [7:0]    pram_q;
  logic [7:0]    scr_q;
  logic          q_pram;
  logic          q_ok;

  logic          pram_hit;
  logic          scr_hit;
  logic [PA-1:0] pram_idx;
  logic [SA-1:0] scr_idx;

  assign pram_idx = req.addr[PA-1:0];
  assign scr_idx  = req.addr[SA-1:0];
  assign pram_hit = req.pram && ({1'b0, req.addr} < 9'(PRAM_BYTES));
  assign scr_hit  = !req.pram && (req.addr >= 8'(pmu_pkg::LO_BYTES))
                    && ({1'b0, req.addr} < 9'(BUF_BYTES));

  always_ff @(posedge clk) begin
    if (req.wr && pram_hit) begin
      pram_mem[pram_idx] <= req.data;
    end
    if (req.wr && scr_hit) begin
      scr_mem[scr_idx] <= req.data;
    end
    if (req.rd) begin
      pram_q <= pram_mem[pram_idx];
      scr_q  <= scr_mem[scr_idx];
      q_pram <= req.pram;
      q_ok   <= pram_hit ? pram_vld[pram_idx] : (scr_hit ? scr_vld[scr_idx] : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pram_vld <= '0;
      scr_vld  <= '0;
    end else if (req.wr) begin
      if (pram_hit) begin
        pram_vld[pram_idx] <= 1'b1;
      end
      if (scr_hit) begin
        scr_vld[scr_idx] <= 1'b1;
      end
    end
  end

  // An entry outside the store, or never written, reads as zero.
  assign rd_data = !q_ok ? 8'h00 : (q_pram ? pram_q : scr_q);

endmodule

`default_nettype wire

/* src/pmu_core.sv */
// ----------------------------------------------------------------------------
// pmu_core
// Protocol sequencer: handles one bus event per step, holds the transfer
// state and the lower scratch bytes, and issues store accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module pmu_core #(
  parameter int BUF_BYTES = pmu_pkg::BUF_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              mode,
  input  logic              to_ready,
  input  logic [7:0]        bus_in,
  input  logic [7:0]        mem_data,
  output pmu_pkg::mem_req_t mem_req,
  output pmu_pkg::rsp_t     rsp
);

  localparam logic [7:0] CMD_NOP_10   = 8'h10;
  localparam logic [7:0] CMD_NOP_E0   = 8'hE0;
  localparam logic [7:0] CMD_NOP_21   = 8'h21;
  localparam logic [7:0] CMD_XPRAM_WR = 8'h32;
  localparam logic [7:0] CMD_XPRAM_RD = 8'h3A;
  localparam logic [7:0] CMD_OPRAM_WR = 8'h31;
  localparam logic [7:0] CMD_OPRAM_RD = 8'h39;
  localparam logic [7:0] CMD_SELFTEST = 8'hEC;
  localparam logic [7:0] CMD_INTR     = 8'h78;
  localparam logic [7:0] CMD_BATTERY  = 8'h68;
  localparam logic [7:0] CMD_SLEEP    = 8'h7F;
  localparam logic [7:0] CMD_PROBE    = 8'hE8;
  localparam logic [7:0] CMD_TIME     = 8'h38;

  localparam logic [8:0] XPRAM_LIMIT = 9'h080;
  localparam logic [7:0] OPRAM_LEN   = 8'd20;
  localparam logic [7:0] OPRAM_HI    = 8'd16;
  localparam logic [7:0] OPRAM_LO    = 8'd8;
  localparam logic [7:0] OPRAM_LO_N  = 8'd4;
  localparam logic [7:0] PROBE_B1    = 8'hEE;
  localparam logic [7:0] PROBE_B2    = 8'h01;
  localparam logic [7:0] PROBE_HIT   = 8'h20;

  typedef enum logic [2:0] {
    PH_CMD     = 3'd0,
    PH_RXLEN   = 3'd1,
    PH_RXBUF   = 3'd2,
    PH_RXDONE  = 3'd3,
    PH_SENDLEN = 3'd4,
    PH_SENDBUF = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t                             phase;
    logic [7:0]                         command;
    logic [7:0]                         length;
    logic [7:0]                         index;
    logic [7:0]                         chunk_left;
    logic                               ptr_in_pram;
    logic [7:0]                         ptr_offset;
    logic [7:0]                         send_byte;
    logic [pmu_pkg::LO_BYTES-1:0][7:0]  b;
    logic [3:0]                         err;
    logic                               ptr_set;
  } work_t;

  phase_t                             phase;
  logic [7:0]                         command;
  logic [7:0]                         length;
  logic [7:0]                         index;
  logic [7:0]                         chunk_left;
  logic                               ptr_in_pram;
  logic [7:0]                         ptr_offset;
  logic [7:0]                         send_byte;
  logic                               send_pending;
  logic                               send_mem;
  logic                               ready_held;
  logic [pmu_pkg::LO_BYTES-1:0][7:0]  lo_buf;

  work_t              w_next;
  logic               pend_next;
  logic               held_next;
  logic               rd_issue;
  pmu_pkg::mem_req_t  req_raw;

  function automatic logic [3:0] first_err(input logic [3:0] cur, input logic [3:0] code);
    return (cur == pmu_pkg::ERR_NONE) ? code : cur;
  endfunction

  function automatic work_t set_ptr(input work_t w_in, input logic pram,
                                    input logic [7:0] off, input logic [7:0] n);
    work_t w;
    w = w_in;
    w.ptr_in_pram = pram;
    w.ptr_offset  = off;
    w.chunk_left  = n;
    return w;
  endfunction

  function automatic work_t start_reply(input work_t w_in, input logic [7:0] code,
                                        input logic [7:0] len);
    work_t w;
    w = w_in;
    w.send_byte = code;
    w.length    = len;
    w.phase     = PH_SENDLEN;
    return w;
  endfunction

  // A chunk with no command-specific pointer goes through the scratch buffer.
  function automatic work_t next_chunk(input work_t w_in);
    work_t      w;
    logic [8:0] n;
    w = w_in;
    n = {1'b0, w.length - w.index};
    if (n >= 9'(BUF_BYTES)) begin
      n = 9'(BUF_BYTES);
    end
    w = set_ptr(w, 1'b0, 8'd0, n[7:0]);
    return w;
  endfunction

  function automatic work_t cmd_op(input work_t w_in);
    work_t      w;
    logic       done;
    logic [8:0] sum01;
    logic [8:0] len_chk;
    w       = w_in;
    w.ptr_set = 1'b0;
    done    = (w.phase == PH_RXDONE);
    sum01   = {1'b0, w.b[0]} + {1'b0, w.b[1]};
    len_chk = {1'b0, w.b[1]} + 9'd2;
    case (w.command)
      CMD_NOP_10, CMD_NOP_E0: begin
      end
      CMD_XPRAM_WR: begin
        if (w.phase == PH_RXBUF) begin
          if (w.index == 8'd0) begin
            if (w.length >= 8'd2) begin
              w = set_ptr(w, 1'b0, 8'd0, 8'd2);
              w.ptr_set = 1'b1;
            end else begin
              w.err = first_err(w.err, pmu_pkg::ERR_XW_LEN);
            end
          end else if (w.index == 8'd2) begin
            if ((len_chk == {1'b0, w.length}) && (sum01 <= XPRAM_LIMIT)) begin
              w = set_ptr(w, 1'b1, w.b[0], w.b[1]);
              w.ptr_set = 1'b1;
            end else begin
              w.err = first_err(w.err, pmu_pkg::ERR_XW_RANGE);
            end
          end else begin
            w.err = first_err(w.err, pmu_pkg::ERR_XW_INDEX);
          end
        end
      end
      CMD_NOP_21: begin
        if (done && (w.length != 8'd0)) begin
          w.err = first_err(w.err, pmu_pkg::ERR_NOP_LEN);
        end
      end
      CMD_SELFTEST: begin
        if (done) begin
          w = start_reply(w, 8'h00, 8'd0);
        end
      end
      CMD_INTR, CMD_BATTERY, CMD_SLEEP: begin
        if (done) begin
          w.b[0] = 8'h00;
          w = start_reply(w, 8'h00, 8'd1);
        end
      end
      CMD_PROBE: begin
        if (done) begin
          w.b[0] = ((w.length == 8'd3) && (w.b[0] == 8'h00) && (w.b[1] == PROBE_B1)
                    && (w.b[2] == PROBE_B2)) ? PROBE_HIT : 8'h00;
          w = start_reply(w, 8'h00, 8'd1);
        end
      end
      CMD_XPRAM_RD: begin
        if (done) begin
          if ((w.length == 8'd2) && (sum01 <= XPRAM_LIMIT)) begin
            w = set_ptr(w, 1'b1, w.b[0], w.b[1]);
            w = start_reply(w, 8'h00, w.b[1]);
          end else begin
            w.err = first_err(w.err, pmu_pkg::ERR_XR_REQ);
          end
        end
      end
      CMD_TIME: begin
        if (done) begin
          if (w.length == 8'd0) begin
            w.b = '0;
            w = start_reply(w, 8'h00, 8'd4);
          end else begin
            w.err = first_err(w.err, pmu_pkg::ERR_TIME_LEN);
          end
        end
      end
      CMD_OPRAM_WR: begin
        if (done) begin
          if (w.length != OPRAM_LEN) begin
            w.err = first_err(w.err, pmu_pkg::ERR_OW_LEN);
          end
        end else if ((w.phase == PH_RXBUF) && (w.length == OPRAM_LEN)) begin
          if (w.index == 8'd0) begin
            w = set_ptr(w, 1'b1, OPRAM_HI, OPRAM_HI);
            w.ptr_set = 1'b1;
          end else if (w.index == OPRAM_HI) begin
            w = set_ptr(w, 1'b1, OPRAM_LO, OPRAM_LO_N);
            w.ptr_set = 1'b1;
          end else begin
            w.err = first_err(w.err, pmu_pkg::ERR_OW_INDEX);
          end
        end
      end
      CMD_OPRAM_RD: begin
        if (done) begin
          if (w.length == 8'd0) begin
            w = start_reply(w, 8'h00, OPRAM_LEN);
          end else begin
            w.err = first_err(w.err, pmu_pkg::ERR_OR_LEN);
          end
        end else if (w.phase == PH_SENDBUF) begin
          if (w.index == 8'd0) begin
            w = set_ptr(w, 1'b1, OPRAM_HI, OPRAM_HI);
            w.ptr_set = 1'b1;
          end else if (w.index == OPRAM_HI) begin
            w = set_ptr(w, 1'b1, OPRAM_LO, OPRAM_LO_N);
            w.ptr_set = 1'b1;
          end else begin
            w.err = first_err(w.err, pmu_pkg::ERR_OR_INDEX);
          end
        end
      end
      default: begin
        if (done) begin
          w.err = first_err(w.err, pmu_pkg::ERR_UNKNOWN);
        end
      end
    endcase
    return w;
  endfunction

  always_comb begin : step_logic
    work_t      w;
    logic       pend;
    logic       rh;
    logic       rw;
    logic       bw;
    logic [7:0] bus;
    logic       tsk;
    logic       chk;
    w.phase       = phase;
    w.command     = command;
    w.length      = length;
    w.index       = index;
    w.chunk_left  = chunk_left;
    w.ptr_in_pram = ptr_in_pram;
    w.ptr_offset  = ptr_offset;
    // A byte fetched from a store on the previous step arrives here.
    w.send_byte   = send_mem ? mem_data : send_byte;
    w.b           = lo_buf;
    w.err         = pmu_pkg::ERR_NONE;
    w.ptr_set     = 1'b0;
    pend     = send_pending;
    rh       = ready_held;
    rw       = 1'b0;
    bw       = 1'b0;
    bus      = 8'h00;
    tsk      = 1'b0;
    chk      = 1'b0;
    rd_issue = 1'b0;
    req_raw  = '0;

    if (mode) begin
      if (pend) begin
        pend = 1'b0;
        bw   = 1'b1;
        bus  = w.send_byte;
        rw   = 1'b1;
        rh   = 1'b0;
      end
    end else begin
      // A ready change that overtakes a pending send drops it.
      if (pend) begin
        pend  = 1'b0;
        w.err = pmu_pkg::ERR_SEND_PEND;
        rw    = 1'b1;
        rh    = 1'b0;
      end
      case (w.phase)
        PH_CMD: begin
          rw = 1'b1;
          if (!to_ready) begin
            rh = 1'b0;
          end else begin
            w.command = bus_in;
            w.phase   = PH_RXLEN;
            rh        = 1'b1;
          end
        end
        PH_RXLEN: begin
          rw = 1'b1;
          if (!to_ready) begin
            rh = 1'b0;
          end else begin
            w.length     = bus_in;
            w.index      = 8'd0;
            w.chunk_left = 8'd0;
            w.phase      = PH_RXBUF;
            chk          = 1'b1;
            rh           = 1'b1;
          end
        end
        PH_RXBUF: begin
          rw = 1'b1;
          if (!to_ready) begin
            rh = 1'b0;
          end else begin
            if (w.chunk_left == 8'd0) begin
              w = cmd_op(w);
              if (!w.ptr_set) begin
                w = next_chunk(w);
              end
            end
            if (!w.ptr_in_pram && (w.ptr_offset < 8'(pmu_pkg::LO_BYTES))) begin
              w.b[w.ptr_offset[pmu_pkg::LO_W-1:0]] = bus_in;
            end else begin
              req_raw.wr = 1'b1;
            end
            req_raw.pram = w.ptr_in_pram;
            req_raw.addr = w.ptr_offset;
            req_raw.data = bus_in;
            w.ptr_offset = w.ptr_offset + 8'd1;
            w.chunk_left = w.chunk_left - 8'd1;
            w.index      = w.index + 8'd1;
            chk          = 1'b1;
            rh           = 1'b1;
          end
        end
        PH_SENDLEN: begin
          if (!to_ready) begin
            rw = 1'b1;
            rh = 1'b1;
          end else begin
            w.send_byte = w.length;
            w.phase     = PH_SENDBUF;
            pend        = 1'b1;
            tsk         = 1'b1;
          end
        end
        PH_SENDBUF: begin
          if (!to_ready) begin
            rw = 1'b1;
            rh = 1'b1;
          end else if (w.index == w.length) begin
            w.phase = PH_CMD;
            bw      = 1'b1;
            bus     = pmu_pkg::BYTE_IDLE;
          end else begin
            if (w.chunk_left == 8'd0) begin
              w = cmd_op(w);
              if (!w.ptr_set) begin
                w = next_chunk(w);
              end
            end
            if (!w.ptr_in_pram && (w.ptr_offset < 8'(pmu_pkg::LO_BYTES))) begin
              w.send_byte = w.b[w.ptr_offset[pmu_pkg::LO_W-1:0]];
            end else begin
              rd_issue   = 1'b1;
              req_raw.rd = 1'b1;
            end
            req_raw.pram = w.ptr_in_pram;
            req_raw.addr = w.ptr_offset;
            w.ptr_offset = w.ptr_offset + 8'd1;
            w.chunk_left = w.chunk_left - 8'd1;
            w.index      = w.index + 8'd1;
            pend         = 1'b1;
            tsk          = 1'b1;
          end
        end
        default: begin
        end
      endcase

      // End of the request: run the command, then reply or return to idle.
      if (chk && (w.index == w.length)) begin
        w.phase = PH_RXDONE;
        w = cmd_op(w);
        if (!w.command[3]) begin
          w.phase = PH_CMD;
          bw      = 1'b1;
          bus     = pmu_pkg::BYTE_IDLE;
        end else begin
          if (w.phase != PH_SENDLEN) begin
            w = start_reply(w, pmu_pkg::BYTE_IDLE, 8'd0);
          end
          w.index = 8'd0;
          pend    = 1'b1;
          tsk     = 1'b1;
        end
      end
    end

    w_next    = w;
    pend_next = pend;
    held_next = rh;

    rsp.ready_write  = rw;
    rsp.ready_level  = rh;
    rsp.bus_write    = bw;
    rsp.bus_out      = bw ? bus : 8'h00;
    rsp.task_request = tsk;
    rsp.error_code   = w.err;
  end

  always_comb begin
    mem_req    = req_raw;
    mem_req.wr = req_raw.wr && step;
    mem_req.rd = req_raw.rd && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CMD;
      command      <= 8'h00;
      length       <= 8'h00;
      index        <= 8'h00;
      chunk_left   <= 8'h00;
      ptr_in_pram  <= 1'b0;
      ptr_offset   <= 8'h00;
      send_byte    <= 8'h00;
      send_pending <= 1'b0;
      send_mem     <= 1'b0;
      ready_held   <= 1'b0;
      lo_buf       <= '0;
    end else if (step) begin
      phase        <= w_next.phase;
      command      <= w_next.command;
      length       <= w_next.length;
      index        <= w_next.index;
      chunk_left   <= w_next.chunk_left;
      ptr_in_pram  <= w_next.ptr_in_pram;
      ptr_offset   <= w_next.ptr_offset;
      send_byte    <= w_next.send_byte;
      send_pending <= pend_next;
      send_mem     <= rd_issue;
      ready_held   <= held_next;
      lo_buf       <= w_next.b;
    end
  end

endmodule

`default_nettype wire

/* src/pmu_command_handshake.sv */
// ----------------------------------------------------------------------------
// pmu_command_handshake
// Power-manager side of a byte-wide command handshake bus.
//
// Each request word is one bus event: a change of the host ready line or a
// delayed send tick. The block takes one word per clock cycle while the
// request side is not stalled, and returns exactly one result word for each:
// the word is held in the input register and passes through the protocol
// sequencer into the result register. A result that waits on a stalled
// output keeps one more word in the input register before the request side
// is stalled. Reply bytes read from the parameter RAM or scratch buffer land
// in a registered memory read port and are used by the next event, so a send
// tick may follow at once. The parameter RAM reads as zero after reset
// through per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pmu_command_handshake_macros.svh"

module pmu_command_handshake #(
  parameter int BUF_BYTES  = pmu_pkg::BUF_BYTES_DEF,
  parameter int PRAM_BYTES = pmu_pkg::PRAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       mode,
  input  logic       to_ready,
  input  logic [7:0] bus_in,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       ready_write,
  output logic       ready_level,
  output logic       bus_write,
  output logic [7:0] bus_out,
  output logic       task_request,
  output logic [3:0] error_code
);

  logic              in_valid_q;
  logic              in_mode_q;
  logic              in_ready_q;
  logic [7:0]        in_bus_q;
  logic              advance;
  logic              step;
  pmu_pkg::rsp_t     rsp_comb;
  pmu_pkg::rsp_t     rsp_q;
  pmu_pkg::mem_req_t mem_req;
  logic [7:0]        mem_data;

  assign advance   = !rsp_valid || !rsp_stall;
  assign step      = in_valid_q && advance;
  assign req_stall = in_valid_q && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!req_stall) begin
      in_valid_q <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_mode_q  <= mode;
      in_ready_q <= to_ready;
      in_bus_q   <= bus_in;
    end
  end

  pmu_core #(
    .BUF_BYTES (BUF_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .mode     (in_mode_q),
    .to_ready (in_ready_q),
    .bus_in   (in_bus_q),
    .mem_data (mem_data),
    .mem_req  (mem_req),
    .rsp      (rsp_comb)
  );

  pmu_store #(
    .BUF_BYTES  (BUF_BYTES),
    .PRAM_BYTES (PRAM_BYTES)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (mem_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_q <= rsp_comb;
    end
  end

  assign ready_write  = rsp_q.ready_write;
  assign ready_level  = rsp_q.ready_level;
  assign bus_write    = rsp_q.bus_write;
  assign bus_out      = rsp_q.bus_out;
  assign task_request = rsp_q.task_request;
  assign error_code   = rsp_q.error_code;

  `PMU_ASSERT_IMPLIES(a_pend_drop_drives_ready, rsp_valid && (error_code == pmu_pkg::ERR_SEND_PEND), ready_write, "dropped send did not drive the ready line")
  `PMU_ASSERT_IMPLIES(a_task_excl_bus, rsp_valid && task_request, !bus_write, "send tick requested while driving the bus")
  `PMU_ASSERT_IMPLIES(a_no_stall_when_empty, !rsp_valid, !req_stall, "request stalled with an empty result register")
  `PMU_ASSERT_NEXT(a_word_moves_on, in_valid_q && !rsp_valid, rsp_valid, "held word did not reach the result register")

endmodule

`default_nettype wire
